// ----- src/lcpi_pkg.sv -----
// ----------------------------------------------------------------------------
// lcpi_pkg
// Shared constants and helpers for the pose interpolator: fixed-point
// format, heading wrap, CORDIC gain and arctangent table, command codes.
// ----------------------------------------------------------------------------
package lcpi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HEAD_W    = 19;
  localparam int POS_W     = 32;
  localparam int RES_W     = 31;
  localparam int ANG_W     = 20;
  localparam int WRAP_W    = 23;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_QU  = (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic signed [WRAP_W-1:0] PI_W     = signed'(PI_QU[WRAP_W-1:0]);
  localparam logic signed [WRAP_W-1:0] TWO_PI_W = signed'(PI_QU[WRAP_W-2:0] << 1);
  localparam logic signed [WRAP_W-1:0] FOUR_PI_W = signed'(PI_QU[WRAP_W-3:0] << 2);

  localparam logic [RES_W-1:0] RES_RESET =
    RES_W'(((64'd1 << (FRAC_BITS + 1)) + 64'd10) / 64'd20);

  // cordic datapath, Q2.30 angles and results
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_ITERS = 28;
  localparam int ITER_W       = 5;
  localparam int ANG_SH       = 30 - FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_LINE = 2'd1;
  localparam logic [1:0] CMD_ARC  = 2'd2;

  function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [ITER_W-1:0] idx);
    logic signed [CORDIC_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      5'd24: v = 34'sd63;
      5'd25: v = 34'sd31;
      5'd26: v = 34'sd15;
      5'd27: v = 34'sd8;
      default: v = '0;
    endcase
    return v;
  endfunction

  // wrap into [-pi, pi); input stays within two turns of the range
  function automatic logic signed [HEAD_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] v);
    logic signed [WRAP_W-1:0] u;
    logic signed [WRAP_W-1:0] r;
    u = v + PI_W;
    if (u < -TWO_PI_W) begin
      r = u + FOUR_PI_W;
    end else if (u < 0) begin
      r = u + TWO_PI_W;
    end else if (u < TWO_PI_W) begin
      r = u;
    end else if (u < FOUR_PI_W) begin
      r = u - TWO_PI_W;
    end else begin
      r = u - FOUR_PI_W;
    end
    return HEAD_W'(r - PI_W);
  endfunction

endpackage

// ----- src/lcpi_cordic.sv -----
// ----------------------------------------------------------------------------
// lcpi_cordic
// Rotation-mode CORDIC, one iteration per cycle, giving cosine and sine in
// Q2.30 of a wrapped heading.
// ----------------------------------------------------------------------------
module lcpi_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [lcpi_pkg::HEAD_W-1:0]   angle,
  output logic                                 done,
  output logic signed [lcpi_pkg::CORDIC_W-1:0] cos_q,
  output logic signed [lcpi_pkg::CORDIC_W-1:0] sin_q
);
  import lcpi_pkg::*;

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERS - 1);

  logic                       busy_r;
  logic                       done_r;
  logic                       neg_r;
  logic [ITER_W-1:0]          iter_r;
  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic signed [CORDIC_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [CORDIC_W-1:0] z0, zs, xsh, ysh;
  logic                       ns;

  always_comb begin
    z0 = CORDIC_W'(angle) <<< ANG_SH;
    zs = z0;
    ns = 1'b0;
    // fold into the right half plane, flip the result afterwards
    if (z0 > HALF_PI_Q30) begin
      zs = z0 - PI_Q30;
      ns = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      zs = z0 + PI_Q30;
      ns = 1'b1;
    end
    xsh = x_r >>> iter_r;
    ysh = y_r >>> iter_r;
    if (!z_r[CORDIC_W-1]) begin
      x_nxt = x_r - ysh;
      y_nxt = y_r + xsh;
      z_nxt = z_r - atan_q30(iter_r);
    end else begin
      x_nxt = x_r + ysh;
      y_nxt = y_r - xsh;
      z_nxt = z_r + atan_q30(iter_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= CORDIC_K;
        y_r    <= '0;
        z_r    <= zs;
        neg_r  <= ns;
        iter_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        if (iter_r == LAST_ITER) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          iter_r <= iter_r + 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_q = neg_r ? -x_r : x_r;
  assign sin_q = neg_r ? -y_r : y_r;

endmodule

// ----- src/linear_circular_pose_interpolator.sv -----
// The block holds a planar pose (x, y, heading) in Q15.16 and walks it along
// straight and circular segments, emitting one pose per step of at most
// the resolution register. A start-pose item gives no pose. Each pose is
// made in order: a step is set up, one CORDIC pass gives a sine/cosine
// pair (two passes per curve step), then two products are formed on the
// shared multiplier, each in a low and a high half and then added to the
// pose, and the pose is handed over. A segment gives at most 64 poses and
// the consumer may stall each one; no new item is taken until the last
// pose has been taken.
// ----------------------------------------------------------------------------
// linear_circular_pose_interpolator
// Sequencer around a shared CORDIC unit and a split 34x34 multiplier.
// ----------------------------------------------------------------------------
module linear_circular_pose_interpolator #(
  parameter int MAX_POSES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lcpi_pkg::RES_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_command,
  input  logic signed [lcpi_pkg::POS_W-1:0]  in_start_x,
  input  logic signed [lcpi_pkg::POS_W-1:0]  in_start_y,
  input  logic signed [lcpi_pkg::HEAD_W-1:0] in_start_heading,
  input  logic signed [lcpi_pkg::POS_W-1:0]  in_length,
  input  logic signed [lcpi_pkg::ANG_W-1:0]  in_angle,
  input  logic signed [lcpi_pkg::POS_W-1:0]  in_radius,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lcpi_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [lcpi_pkg::POS_W-1:0]  out_pos_y,
  output logic signed [lcpi_pkg::HEAD_W-1:0] out_pos_heading,
  output logic                               out_last,
  output logic                               out_overflow
);
  import lcpi_pkg::*;

  localparam int CNT_W = $clog2(MAX_POSES + 1);
  localparam int ACC_W = 2 * CORDIC_W;
  localparam int HALF_W = CORDIC_W / 2;
  localparam int PROD_W = CORDIC_W + HALF_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_COS1, S_COS2, S_MUL_LO, S_MUL_HI, S_ACC, S_EMIT
  } state_t;

  state_t                     state_r;
  logic [RES_W-1:0]           res_r;
  logic [POS_W-1:0]           pose_x_r, pose_y_r;
  logic signed [HEAD_W-1:0]   theta_r;
  logic                       arc_r, neg_r, rneg_r, ysel_r;
  logic [POS_W-1:0]           mag_r, prog_r, step_r;
  logic signed [POS_W-1:0]    rad_r;
  logic signed [CORDIC_W-1:0] c1_r, s1_r, c2_r, s2_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       out_valid_r, out_last_r, out_ovf_r;
  logic [POS_W-1:0]           out_x_r, out_y_r;
  logic signed [HEAD_W-1:0]   out_h_r;

  logic                       cord_start, cord_done;
  logic signed [HEAD_W-1:0]   cord_angle;
  logic signed [CORDIC_W-1:0] cord_cos, cord_sin;

  logic [RES_W-1:0]           res_eff;
  logic [POS_W-1:0]           rem, step_nxt;
  logic signed [WRAP_W-1:0]   dt, theta_w;
  logic signed [HEAD_W-1:0]   theta_adv, theta_nxt;
  logic signed [CORDIC_W-1:0] mul_a, mul_b;
  logic signed [HALF_W:0]     mul_op;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    rnd_full;
  logic [POS_W-1:0]           delta;
  logic signed [ANG_W:0]      ang_ext, ang_abs;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       more, last_nxt;

  lcpi_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (cord_angle),
    .done  (cord_done),
    .cos_q (cord_cos),
    .sin_q (cord_sin)
  );

  always_comb begin
    res_eff  = (res_r == '0) ? RES_W'(1) : res_r;
    rem      = mag_r - prog_r;
    step_nxt = (rem < {1'b0, res_eff}) ? rem : {1'b0, res_eff};
    // curve steps are bounded by the angle field, so they fit the wrap width
    dt       = signed'({1'b0, step_r[WRAP_W-2:0]});
    if (neg_r) begin
      dt = -dt;
    end
    theta_w   = WRAP_W'(theta_r);
    theta_adv = wrap_angle(theta_w + dt);
    theta_nxt = wrap_angle(rneg_r ? theta_w - dt : theta_w + dt);

    cord_start = (state_r == S_STEP) || (state_r == S_COS1 && cord_done && arc_r);
    cord_angle = (state_r == S_STEP) ? theta_r : theta_adv;

    if (arc_r) begin
      mul_a = CORDIC_W'(rad_r);
      mul_b = ysel_r ? (c1_r - c2_r) : (s2_r - s1_r);
    end else begin
      mul_a = signed'({2'b00, step_r});
      if (neg_r) begin
        mul_a = -mul_a;
      end
      mul_b = ysel_r ? s1_r : c1_r;
    end
    // upper half carries the sign, lower half is taken as unsigned
    if (state_r == S_MUL_HI) begin
      mul_op = (HALF_W + 1)'(signed'(mul_b[CORDIC_W-1:HALF_W]));
    end else begin
      mul_op = signed'({1'b0, mul_b[HALF_W-1:0]});
    end
    prod = PROD_W'(mul_a) * PROD_W'(mul_op);

    // round half up at 30 fraction bits
    rnd_full = (acc_r + (ACC_W'(1) <<< 29)) >>> 30;
    delta    = rnd_full[POS_W-1:0];
    if (arc_r && neg_r) begin
      delta = -delta;
    end

    ang_ext = (ANG_W + 1)'(in_angle);
    ang_abs = ang_ext[ANG_W] ? -ang_ext : ang_ext;

    cnt_inc  = cnt_r + 1'b1;
    more     = prog_r < mag_r;
    last_nxt = !(more && (cnt_inc < CNT_W'(MAX_POSES)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= RES_RESET;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      theta_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ysel_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        res_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            prog_r <= '0;
            cnt_r  <= '0;
            case (in_command)
              CMD_LOAD: begin
                pose_x_r <= in_start_x;
                pose_y_r <= in_start_y;
                theta_r  <= wrap_angle(WRAP_W'(in_start_heading));
              end
              CMD_LINE: begin
                arc_r   <= 1'b0;
                neg_r   <= in_length[POS_W-1];
                mag_r   <= in_length[POS_W-1] ? -in_length : in_length;
                state_r <= S_STEP;
              end
              CMD_ARC: begin
                arc_r   <= 1'b1;
                neg_r   <= !(in_angle > 0);
                rneg_r  <= in_radius[POS_W-1];
                rad_r   <= in_radius;
                mag_r   <= POS_W'($unsigned(ang_abs));
                state_r <= S_STEP;
              end
              default: begin
              end
            endcase
          end
        end
        S_STEP: begin
          step_r  <= step_nxt;
          prog_r  <= prog_r + step_nxt;
          state_r <= S_COS1;
        end
        S_COS1: begin
          if (cord_done) begin
            c1_r   <= cord_cos;
            s1_r   <= cord_sin;
            ysel_r <= 1'b0;
            state_r <= arc_r ? S_COS2 : S_MUL_LO;
          end
        end
        S_COS2: begin
          if (cord_done) begin
            c2_r    <= cord_cos;
            s2_r    <= cord_sin;
            state_r <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          acc_r   <= ACC_W'(prod);
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc_r   <= acc_r + (ACC_W'(prod) <<< HALF_W);
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (!ysel_r) begin
            pose_x_r <= pose_x_r + delta;
            ysel_r   <= 1'b1;
            state_r  <= S_MUL_LO;
          end else begin
            pose_y_r    <= pose_y_r + delta;
            out_x_r     <= pose_x_r;
            out_y_r     <= pose_y_r + delta;
            out_h_r     <= arc_r ? theta_nxt : theta_r;
            if (arc_r) begin
              theta_r <= theta_nxt;
            end
            out_last_r  <= last_nxt;
            out_ovf_r   <= last_nxt && more;
            cnt_r       <= cnt_inc;
            out_valid_r <= 1'b1;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= out_last_r ? S_IDLE : S_STEP;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;
  assign out_pos_heading = out_h_r;
  assign out_last        = out_last_r;
  assign out_overflow    = out_ovf_r;

  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> out_last)
    else $error("overflow flagged on a pose that is not the last");

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("item accepted while a pose is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POSES))
    else $error("pose count beyond limit");

  a_prog_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (prog_r <= mag_r))
    else $error("segment progress past its length");

endmodule

// ----- tb/linear_circular_pose_interpolator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_circular_pose_interpolator_tb
// Drives start-pose, straight and curve items with random idling on both
// sides and checks every emitted pose against an in-bench fixed-point pose
// tracker with its own CORDIC, under several resolution settings.
// ----------------------------------------------------------------------------
module linear_circular_pose_interpolator_tb;
  import lcpi_pkg::*;

  localparam int  WATCHDOG_LIMIT = 40000;
  localparam int  SEG_MAX        = 64;
  localparam longint ATAN_TAB [28] = '{
    843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 8
  };

  typedef struct {
    logic [1:0]                 command;
    logic signed [POS_W-1:0]    start_x;
    logic signed [POS_W-1:0]    start_y;
    logic signed [HEAD_W-1:0]   start_heading;
    logic signed [POS_W-1:0]    length;
    logic signed [ANG_W-1:0]    angle;
    logic signed [POS_W-1:0]    radius;
  } seg_item_t;

  typedef struct {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [HEAD_W-1:0] heading;
    logic              last;
    logic              overflow;
  } pose_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [RES_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_command;
  logic signed [POS_W-1:0] in_start_x;
  logic signed [POS_W-1:0] in_start_y;
  logic signed [HEAD_W-1:0] in_start_heading;
  logic signed [POS_W-1:0] in_length;
  logic signed [ANG_W-1:0] in_angle;
  logic signed [POS_W-1:0] in_radius;
  logic out_valid;
  logic out_stall;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [HEAD_W-1:0] out_pos_heading;
  logic out_last;
  logic out_overflow;

  // tracked pose and resolution
  logic [31:0] trk_x;
  logic [31:0] trk_y;
  longint      trk_theta;
  longint      trk_res;

  pose_t expected_poses[$];
  int    error_count = 0;
  int    idle_pct;
  int    stall_pct;
  int    quiet_cycles;

  linear_circular_pose_interpolator dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_start_heading(in_start_heading), .in_length(in_length),
    .in_angle(in_angle), .in_radius(in_radius),
    .out_valid(out_valid), .out_stall(out_stall), .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y), .out_pos_heading(out_pos_heading),
    .out_last(out_last), .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint pi_fix();
    return longint'(PI_QU);
  endfunction

  function automatic longint wrap_heading(input longint v);
    longint p;
    longint r;
    p = pi_fix();
    r = (v + p) % (2 * p);
    if (r < 0) r += 2 * p;
    return r - p;
  endfunction

  function automatic longint round_q30(input longint p);
    return (p + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic void sin_cos(input longint a, output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit     neg;
    z = a * (longint'(1) <<< (30 - FRAC_BITS));
    x = longint'(CORDIC_K);
    y = 0;
    neg = 1'b0;
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      neg = 1'b1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      neg = 1'b1;
    end
    for (int i = 0; i < 28; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic void push_pose();
    pose_t p;
    p.x = trk_x;
    p.y = trk_y;
    p.heading = HEAD_W'(trk_theta);
    p.last = 1'b0;
    p.overflow = 1'b0;
    expected_poses.insert(expected_poses.size(), p);
  endfunction

  // walk the tracked pose through one segment and queue its poses
  function automatic void walk_segment(input seg_item_t it);
    longint res;
    longint mag;
    longint done;
    longint step;
    longint dir;
    longint sg;
    longint sr;
    longint dt;
    longint c1;
    longint s1;
    longint c2;
    longint s2;
    longint rad;
    int     n;
    res = (trk_res == 0) ? 1 : trk_res;
    done = 0;
    n = 0;
    if (it.command == CMD_LOAD) begin
      trk_x = it.start_x;
      trk_y = it.start_y;
      trk_theta = wrap_heading(longint'(it.start_heading));
      return;
    end
    if (it.command == CMD_LINE) begin
      dir = (it.length >= 0) ? 1 : -1;
      mag = (it.length >= 0) ? longint'(it.length) : -longint'(it.length);
      do begin
        step = (mag - done < res) ? mag - done : res;
        done += step;
        sin_cos(trk_theta, c1, s1);
        trk_x += 32'(round_q30(dir * step * c1));
        trk_y += 32'(round_q30(dir * step * s1));
        push_pose();
        n++;
      end while (done < mag && n < SEG_MAX);
    end else if (it.command == CMD_ARC) begin
      rad = longint'(it.radius);
      sg = (it.angle > 0) ? 1 : -1;
      sr = (it.radius >= 0) ? 1 : -1;
      mag = (it.angle >= 0) ? longint'(it.angle) : -longint'(it.angle);
      do begin
        step = (mag - done < res) ? mag - done : res;
        done += step;
        dt = sg * step;
        sin_cos(trk_theta, c1, s1);
        sin_cos(wrap_heading(trk_theta + dt), c2, s2);
        trk_x += 32'(sg * round_q30(rad * (s2 - s1)));
        trk_y += 32'(sg * round_q30(rad * (c1 - c2)));
        trk_theta = wrap_heading(trk_theta + sr * dt);
        push_pose();
        n++;
      end while (done < mag && n < SEG_MAX);
    end else begin
      return;
    end
    expected_poses[$].last = 1'b1;
    expected_poses[$].overflow = (done < mag);
  endfunction

  task automatic send_item(input seg_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command = it.command;
    in_start_x = it.start_x;
    in_start_y = it.start_y;
    in_start_heading = it.start_heading;
    in_length = it.length;
    in_angle = it.angle;
    in_radius = it.radius;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    walk_segment(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_resolution(input longint r);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = RES_W'(r);
    @(negedge clk);
    cfg_we = 1'b0;
    trk_res = r;
  endtask

  function automatic seg_item_t make_item(input logic [1:0] cmd, input longint len,
                                          input longint ang, input longint rad);
    seg_item_t it;
    it.command = cmd;
    it.start_x = $urandom;
    it.start_y = $urandom;
    it.start_heading = HEAD_W'($urandom_range(411775) - 205888);
    it.length = POS_W'(len);
    it.angle = ANG_W'(ang);
    it.radius = POS_W'(rad);
    return it;
  endfunction

  function automatic seg_item_t make_load(input longint x, input longint y, input longint h);
    seg_item_t it;
    it = make_item(CMD_LOAD, $urandom, $urandom_range(411775), $urandom);
    it.start_x = POS_W'(x);
    it.start_y = POS_W'(y);
    it.start_heading = HEAD_W'(h);
    return it;
  endfunction

  task automatic test_load_pose();
    send_item(make_load(32'h7fffffff, -32'sh80000000, 205887));
    send_item(make_item(CMD_LINE, 6554, 0, 0));
    send_item(make_load(-32'sh80000000, 32'h7fffffff, -205888));
    send_item(make_item(CMD_LINE, 20000, 0, 0));
  endtask

  task automatic test_straight();
    send_item(make_load(0, 0, 51472));
    send_item(make_item(CMD_LINE, 0, 0, 0));
    send_item(make_item(CMD_LINE, -30000, 0, 0));
    send_item(make_item(CMD_LINE, 13108, 0, 0));
    send_item(make_item(CMD_LINE, 64'h7fffffff, 0, 0));
    send_item(make_item(CMD_LINE, -64'sh80000000, 0, 0));
  endtask

  task automatic test_curve();
    send_item(make_item(CMD_ARC, 0, 0, 65536));
    send_item(make_item(CMD_ARC, 0, 411775, -65536));
    send_item(make_item(CMD_ARC, 0, -411775, 64'h7fffffff));
    send_item(make_item(CMD_ARC, 0, 20000, -64'sh80000000));
    send_item(make_item(CMD_ARC, 0, -30000, 0));
    send_item(make_item(CMD_ARC, 0, 6554, 131072));
  endtask

  task automatic test_unknown_command();
    send_item(make_item(2'd3, $urandom, 200000, $urandom));
    send_item(make_item(CMD_LINE, 7000, 0, 0));
  endtask

  task automatic test_resolution_extremes();
    set_resolution(64'h7fffffff);
    send_item(make_item(CMD_LINE, 64'h7fffffff, 0, 0));
    send_item(make_item(CMD_ARC, 0, -411775, 327680));
    set_resolution(1);
    send_item(make_item(CMD_LINE, 5, 0, 0));
    send_item(make_item(CMD_ARC, 0, 100, -65536));
    send_item(make_item(CMD_ARC, 0, -3, 65536));
  endtask

  task automatic test_random(input int count);
    int     pick;
    longint span;
    longint len;
    longint ang;
    longint rad;
    seg_item_t it;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      span = trk_res * 6;
      if (span > 64'h7fffffff) span = 64'h7fffffff;
      if ($urandom_range(9) < 8) len = $urandom_range(32'(span));
      else len = longint'($urandom);
      if ($urandom_range(1)) len = -len;
      if ($urandom_range(9) < 8) ang = $urandom_range(32'(span < 411775 ? span : 411775));
      else ang = $urandom_range(411775);
      if ($urandom_range(1)) ang = -ang;
      if ($urandom_range(1)) rad = longint'($signed($urandom)) >>> $urandom_range(31);
      else rad = longint'($signed($urandom));
      if (pick < 15) it = make_item(CMD_LOAD, len, ang, rad);
      else if (pick < 55) it = make_item(CMD_LINE, len, ang, rad);
      else if (pick < 95) it = make_item(CMD_ARC, len, ang, rad);
      else it = make_item(2'd3, len, ang, rad);
      send_item(it);
    end
  endtask

  // receiver stall, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        $error("unexpected pose x=%h y=%h", out_pos_x, out_pos_y);
        error_count++;
      end else begin
        e = expected_poses.pop_front();
        if (out_pos_x !== e.x) begin
          $error("pos_x expected %h got %h", e.x, out_pos_x);
          error_count++;
        end
        if (out_pos_y !== e.y) begin
          $error("pos_y expected %h got %h", e.y, out_pos_y);
          error_count++;
        end
        if (out_pos_heading !== e.heading) begin
          $error("pos_heading expected %h got %h", e.heading, out_pos_heading);
          error_count++;
        end
        if (out_last !== e.last) begin
          $error("last expected %b got %b", e.last, out_last);
          error_count++;
        end
        if (out_overflow !== e.overflow) begin
          $error("overflow expected %b got %b", e.overflow, out_overflow);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    idle_pct = 34;
    stall_pct = 67;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = CMD_LOAD;
    in_start_x = '0;
    in_start_y = '0;
    in_start_heading = '0;
    in_length = '0;
    in_angle = '0;
    in_radius = '0;
    trk_x = '0;
    trk_y = '0;
    trk_theta = 0;
    trk_res = longint'(RES_RESET);
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_load_pose();
    test_straight();
    test_curve();
    test_unknown_command();
    test_resolution_extremes();

    set_resolution(6554);
    test_random(70);
    idle_pct = 67;
    stall_pct = 34;
    set_resolution(40000);
    test_random(70);
    idle_pct = 0;
    stall_pct = 0;
    set_resolution(1500);
    test_random(60);

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lcpi_pkg.sv
src/lcpi_cordic.sv
src/linear_circular_pose_interpolator.sv
tb/linear_circular_pose_interpolator_tb.sv
